>>> rtl/ctg_pkg.sv
// ----------------------------------------------------------------------------
// ctg_pkg: shared types and constants of the text console grid writer
// Transfer payload structs, operation and result codes, character codes and
// the sequencer state type.
// ----------------------------------------------------------------------------
package ctg_pkg;

  // Field widths of the transfer payloads
  localparam int unsigned OP_W       = 2;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned ROW_FLD_W  = 5;
  localparam int unsigned COL_FLD_W  = 6;
  localparam int unsigned KIND_W     = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_PRINT = 2'd0;
  localparam logic [OP_W-1:0] OP_KEY   = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LINE   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CELL   = 2'd2;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_BACK     = 8'd8;
  localparam logic [CHAR_W-1:0] CH_NEWLINE  = 8'd10;
  localparam logic [CHAR_W-1:0] CH_SPACE    = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PRINT_LO = 8'd32;
  localparam logic [CHAR_W-1:0] CH_PRINT_HI = 8'd127;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [CHAR_W-1:0]    byte_in;
    logic [ROW_FLD_W-1:0] read_row;
    logic [COL_FLD_W-1:0] read_col;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [ROW_FLD_W-1:0] cursor_row_out;
    logic [COL_FLD_W-1:0] cursor_col_out;
    logic [CHAR_W-1:0]    data_out;
    logic                 last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_PUT_ADDR,
    S_PUT_WR,
    S_NEWLINE,
    S_BLANK_ADDR,
    S_BLANK_WR,
    S_BACK,
    S_BACK_ADDR,
    S_BACK_WR,
    S_READ,
    S_EMIT,
    S_LINE_RD,
    S_LINE_OUT
  } seq_state_e;

endpackage

>>> rtl/text_console_grid_writer.sv
// ----------------------------------------------------------------------------
// text_console_grid_writer: character-cell text console
// Grid of character codes with cursor, scrolling and a key-line buffer;
// results leave through an output register.
//
//   channel  direction  payload     handshake
//   input    in         in_item_t   in_valid_i / in_stall_o
//   output   out        out_item_t  out_valid_o / out_stall_i
//
// After reset the grid is blanked cell by cell, with the input stalled. A
// scroll blanks the new bottom row cell by cell, and enter sends the typed
// line out byte by byte. One item is worked at a time. A stalled output
// holds the sequencer at its emit or line-output step.
// ----------------------------------------------------------------------------
module text_console_grid_writer
  import ctg_pkg::*;
#(
  parameter int unsigned ROW_COUNT = 25,
  parameter int unsigned COL_COUNT = 40,
  parameter int unsigned LINE_MAX  = 63
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic      res_valid;
  out_item_t res;
  logic      res_free;
  logic      out_valid_q, out_valid_d;
  out_item_t out_data_q;

  ctg_seq #(
    .ROW_COUNT (ROW_COUNT),
    .COL_COUNT (COL_COUNT),
    .LINE_MAX  (LINE_MAX)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_data_i),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_free_i  (res_free)
  );

  // Output register: takes a new result when empty or being transferred
  assign res_free    = !out_valid_q || !out_stall_i;
  assign out_valid_d = (res_valid && res_free) || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_free) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

>>> rtl/ctg_ram.sv
// ----------------------------------------------------------------------------
// ctg_ram: simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ctg_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 64,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/ctg_addr_unit.sv
// ----------------------------------------------------------------------------
// ctg_addr_unit: shared cell address unit
// Maps a logical (row, column) through the rotating top-row offset to a
// physical grid address; the result is registered for the next cycle.
// ----------------------------------------------------------------------------
module ctg_addr_unit #(
  parameter int unsigned ROW_COUNT = 25,
  parameter int unsigned COL_COUNT = 40,
  parameter int unsigned ROW_W     = $clog2(ROW_COUNT),
  parameter int unsigned COL_W     = $clog2(COL_COUNT),
  parameter int unsigned ADDR_W    = $clog2(ROW_COUNT * COL_COUNT)
) (
  input  logic              clk_i,
  input  logic [ROW_W-1:0]  row_i,
  input  logic [COL_W-1:0]  col_i,
  input  logic [ROW_W-1:0]  top_i,
  output logic [ADDR_W-1:0] addr_o
);

  logic [ROW_W:0]    row_sum;
  logic [ROW_W:0]    phys_row;
  logic [ADDR_W-1:0] addr_d;
  logic [ADDR_W-1:0] addr_q;

  // Rotate row by the top offset (mod ROW_COUNT), then row * COL_COUNT + col
  always_comb begin
    row_sum = {1'b0, row_i} + {1'b0, top_i};
    if (row_sum >= (ROW_W+1)'(ROW_COUNT)) begin
      phys_row = row_sum - (ROW_W+1)'(ROW_COUNT);
    end else begin
      phys_row = row_sum;
    end
    addr_d = ADDR_W'(phys_row * COL_COUNT) + ADDR_W'(col_i);
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
  end

  assign addr_o = addr_q;

endmodule

>>> rtl/ctg_seq.sv
// ----------------------------------------------------------------------------
// ctg_seq: console sequencer
// Small state machine that steps each operation through the shared address
// unit, the character grid RAM and the key-line RAM, one access per cycle while the output is free.
// ----------------------------------------------------------------------------
module ctg_seq
  import ctg_pkg::*;
#(
  parameter int unsigned ROW_COUNT = 25,
  parameter int unsigned COL_COUNT = 40,
  parameter int unsigned LINE_MAX  = 63
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      res_valid_o,
  output out_item_t res_o,
  input  logic      res_free_i
);

  localparam int unsigned ROW_W  = $clog2(ROW_COUNT);
  localparam int unsigned COL_W  = $clog2(COL_COUNT);
  localparam int unsigned CELLS  = ROW_COUNT * COL_COUNT;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam int unsigned LDEPTH = LINE_MAX + 1;
  localparam int unsigned LINE_W = $clog2(LDEPTH);

  localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROW_COUNT - 1);
  localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COL_COUNT - 1);
  localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);
  localparam logic [LINE_W-1:0] LEN_MAX   = LINE_W'(LINE_MAX);

  seq_state_e state_q, state_d;

  logic [OP_W-1:0]      op_q, op_d;
  logic [CHAR_W-1:0]    byte_q, byte_d;
  logic [ROW_FLD_W-1:0] rr_q, rr_d;
  logic [COL_FLD_W-1:0] rc_q, rc_d;
  logic [ROW_W-1:0]     row_q, row_d;
  logic [COL_W-1:0]     col_q, col_d;
  logic [ROW_W-1:0]     top_q, top_d;
  logic [LINE_W-1:0]    len_q, len_d;
  logic [LINE_W-1:0]    idx_q, idx_d;
  logic [COL_W-1:0]     bcol_q, bcol_d;
  logic [ADDR_W-1:0]    clr_q, clr_d;

  logic              accept;
  logic              is_enter;
  logic              in_range;
  logic              printable;

  logic [ROW_W-1:0]  au_row;
  logic [COL_W-1:0]  au_col;
  logic [ADDR_W-1:0] au_addr;

  logic              grid_we;
  logic [ADDR_W-1:0] grid_waddr;
  logic [CHAR_W-1:0] grid_wdata;
  logic              grid_re;
  logic [CHAR_W-1:0] grid_rdata;

  logic              line_we;
  logic [CHAR_W-1:0] line_wdata;
  logic              line_re;
  logic [CHAR_W-1:0] line_rdata;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);
  assign is_enter   = (op_q == OP_KEY) && (byte_q == CH_NEWLINE);
  assign in_range   = (int'(rr_q) < ROW_COUNT) && (int'(rc_q) < COL_COUNT);
  assign printable  = (byte_q inside {[CH_PRINT_LO:CH_PRINT_HI]});

  // Shared address unit
  ctg_addr_unit #(
    .ROW_COUNT (ROW_COUNT),
    .COL_COUNT (COL_COUNT),
    .ROW_W     (ROW_W),
    .COL_W     (COL_W),
    .ADDR_W    (ADDR_W)
  ) u_addr (
    .clk_i  (clk_i),
    .row_i  (au_row),
    .col_i  (au_col),
    .top_i  (top_q),
    .addr_o (au_addr)
  );

  // Character grid
  ctg_ram #(
    .WIDTH  (CHAR_W),
    .DEPTH  (CELLS),
    .ADDR_W (ADDR_W)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (grid_we),
    .waddr_i (grid_waddr),
    .wdata_i (grid_wdata),
    .re_i    (grid_re),
    .raddr_i (au_addr),
    .rdata_o (grid_rdata)
  );

  // Key-line buffer
  ctg_ram #(
    .WIDTH  (CHAR_W),
    .DEPTH  (LDEPTH),
    .ADDR_W (LINE_W)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (len_q),
    .wdata_i (line_wdata),
    .re_i    (line_re),
    .raddr_i (idx_q),
    .rdata_o (line_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == CELL_LAST) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (op_q)
          OP_PRINT: begin
            if (byte_q == CH_NEWLINE)   state_d = S_NEWLINE;
            else if (byte_q == CH_BACK) state_d = S_BACK;
            else                        state_d = S_PUT_ADDR;
          end
          OP_KEY: begin
            if (byte_q == CH_BACK) begin
              state_d = (len_q != '0) ? S_BACK : S_EMIT;
            end else if (byte_q == CH_NEWLINE) begin
              state_d = S_NEWLINE;
            end else if (printable && (len_q < LEN_MAX)) begin
              state_d = S_PUT_ADDR;
            end else begin
              state_d = S_EMIT;
            end
          end
          OP_READ: state_d = in_range ? S_READ : S_EMIT;
          default: state_d = S_EMIT;
        endcase
      end
      S_PUT_ADDR: state_d = S_PUT_WR;
      S_PUT_WR: begin
        state_d = (col_q == COL_LAST) ? S_NEWLINE : S_EMIT;
      end
      S_NEWLINE: begin
        if (row_q == ROW_LAST) state_d = S_BLANK_ADDR;
        else                   state_d = is_enter ? S_LINE_RD : S_EMIT;
      end
      S_BLANK_ADDR: state_d = S_BLANK_WR;
      S_BLANK_WR: begin
        if (bcol_q == COL_LAST) state_d = is_enter ? S_LINE_RD : S_EMIT;
        else                    state_d = S_BLANK_ADDR;
      end
      S_BACK:      state_d = S_BACK_ADDR;
      S_BACK_ADDR: state_d = S_BACK_WR;
      S_BACK_WR:   state_d = S_EMIT;
      S_READ:      state_d = S_EMIT;
      S_EMIT: begin
        if (res_free_i) state_d = S_IDLE;
      end
      S_LINE_RD: state_d = S_LINE_OUT;
      S_LINE_OUT: begin
        if (res_free_i) state_d = (idx_q == len_q) ? S_IDLE : S_LINE_RD;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath, memory controls and result
  always_comb begin
    op_d   = op_q;
    byte_d = byte_q;
    rr_d   = rr_q;
    rc_d   = rc_q;
    row_d  = row_q;
    col_d  = col_q;
    top_d  = top_q;
    len_d  = len_q;
    idx_d  = idx_q;
    bcol_d = bcol_q;
    clr_d  = clr_q;

    au_row = row_q;
    au_col = col_q;

    grid_we    = 1'b0;
    grid_waddr = au_addr;
    grid_wdata = CH_SPACE;
    grid_re    = 1'b0;
    line_we    = 1'b0;
    line_wdata = byte_q;
    line_re    = 1'b0;

    res_valid_o          = 1'b0;
    res_o.kind           = KIND_STATUS;
    res_o.cursor_row_out = ROW_FLD_W'(row_q);
    res_o.cursor_col_out = COL_FLD_W'(col_q);
    res_o.data_out       = '0;
    res_o.last           = 1'b1;

    case (state_q)
      // Blank every cell after reset
      S_CLEAR: begin
        grid_we    = 1'b1;
        grid_waddr = clr_q;
        clr_d      = clr_q + 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          op_d   = in_item_i.op;
          byte_d = in_item_i.byte_in;
          rr_d   = in_item_i.read_row;
          rc_d   = in_item_i.read_col;
        end
      end
      // Key-line edits; read address goes to the address unit
      S_DISPATCH: begin
        au_row = ROW_W'(rr_q);
        au_col = COL_W'(rc_q);
        idx_d  = '0;
        if (op_q == OP_KEY) begin
          if (byte_q == CH_BACK) begin
            if (len_q != '0) len_d = len_q - 1'b1;
          end else if (byte_q == CH_NEWLINE) begin
            line_we    = 1'b1;
            line_wdata = CH_NEWLINE;
          end else if (printable && (len_q < LEN_MAX)) begin
            line_we = 1'b1;
            len_d   = len_q + 1'b1;
          end
        end
      end
      // Store the character and advance the column
      S_PUT_WR: begin
        grid_we    = 1'b1;
        grid_wdata = byte_q;
        if (col_q != COL_LAST) col_d = col_q + 1'b1;
      end
      // New line; at the bottom rotate the top row and blank it
      S_NEWLINE: begin
        col_d  = '0;
        bcol_d = '0;
        if (row_q == ROW_LAST) begin
          top_d = (top_q == ROW_LAST) ? '0 : top_q + 1'b1;
        end else begin
          row_d = row_q + 1'b1;
        end
      end
      S_BLANK_ADDR: begin
        au_row = ROW_LAST;
        au_col = bcol_q;
      end
      S_BLANK_WR: begin
        grid_we = 1'b1;
        bcol_d  = bcol_q + 1'b1;
      end
      // Step the cursor back, crossing to the row above
      S_BACK: begin
        if (col_q != '0) begin
          col_d = col_q - 1'b1;
        end else if (row_q != '0) begin
          row_d = row_q - 1'b1;
          col_d = COL_LAST;
        end
      end
      S_BACK_WR: grid_we = 1'b1;
      S_READ:    grid_re = 1'b1;
      S_EMIT: begin
        res_valid_o = 1'b1;
        if (op_q == OP_READ) begin
          res_o.kind     = KIND_CELL;
          res_o.data_out = in_range ? grid_rdata : '0;
        end
      end
      S_LINE_RD: line_re = 1'b1;
      // Send one line byte; the newline closes the run
      S_LINE_OUT: begin
        res_valid_o    = 1'b1;
        res_o.kind     = KIND_LINE;
        res_o.data_out = line_rdata;
        res_o.last     = (idx_q == len_q);
        if (res_free_i) begin
          if (idx_q == len_q) len_d = '0;
          else                idx_d = idx_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      row_q   <= '0;
      col_q   <= '0;
      top_q   <= '0;
      len_q   <= '0;
      idx_q   <= '0;
      bcol_q  <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      top_q   <= top_d;
      len_q   <= len_d;
      idx_q   <= idx_d;
      bcol_q  <= bcol_d;
      clr_q   <= clr_d;
    end
  end

  // Captured item
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    byte_q <= byte_d;
    rr_q   <= rr_d;
    rc_q   <= rc_d;
  end

endmodule

>>> sim/tb_text_console_grid_writer.sv
// ----------------------------------------------------------------------------
// tb_text_console_grid_writer: self-checking bench of the text console
// Drives print, key, read and undefined items through the valid/stall input
// channel. A cycle-free model of the grid, cursor and typed line predicts
// every result, and each output transfer is compared field by field against
// the oldest prediction. Both channels idle and stall at random. The receiver
// also holds off once for a long stretch to fill the block up.
// ----------------------------------------------------------------------------
module tb_text_console_grid_writer;
  import ctg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROWS         = 25;
  localparam int COLS         = 40;
  localparam int LINE_CAP     = 63;
  localparam int DRAIN_CYCLES = 200;
  localparam int DRAIN_LIMIT  = 50000;

  // op code 3 has no package name; the block treats it as a no-op
  localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  // Console model state
  logic [7:0] screen_model [ROWS*COLS];
  logic [4:0] cur_r;
  logic [5:0] cur_c;
  logic [7:0] typed_line [LINE_CAP+1];
  logic [6:0] typed_len;

  out_item_t expected_results [$];
  int        mismatch_count = 0;

  // Traffic shaping knobs, changed by the tests
  int send_gap_max = 3;
  int burst_left   = 0;
  int stall_pct    = 30;
  int hold_request = 0;

  text_console_grid_writer #(
    .ROW_COUNT(ROWS),
    .COL_COUNT(COLS),
    .LINE_MAX (LINE_CAP)
  ) DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Run limit
  initial begin : watchdog
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Console model
  // ---------------------------------------------------------------------------
  function automatic void model_reset();
    for (int i = 0; i < ROWS*COLS; i++) screen_model[i] = CH_SPACE;
    for (int i = 0; i <= LINE_CAP; i++) typed_line[i] = '0;
    cur_r     = '0;
    cur_c     = '0;
    typed_len = '0;
  endfunction

  // shift every row up one and blank the bottom row
  function automatic void screen_scroll();
    for (int i = 0; i < (ROWS-1)*COLS; i++) screen_model[i] = screen_model[i+COLS];
    for (int i = (ROWS-1)*COLS; i < ROWS*COLS; i++) screen_model[i] = CH_SPACE;
    if (cur_r > 0) cur_r--;
  endfunction

  function automatic void cursor_newline();
    cur_c = '0;
    cur_r++;
    if (cur_r >= ROWS) screen_scroll();
  endfunction

  // backspace: wraps to the row above, stays put at the top-left corner
  function automatic void cursor_back();
    if (cur_c > 0) begin
      cur_c--;
    end else if (cur_r > 0) begin
      cur_r--;
      cur_c = 6'(COLS - 1);
    end
    screen_model[cur_r*COLS + cur_c] = CH_SPACE;
  endfunction

  function automatic void put_char(logic [7:0] b);
    if (b == CH_NEWLINE) begin
      cursor_newline();
    end else if (b == CH_BACK) begin
      cursor_back();
    end else begin
      screen_model[cur_r*COLS + cur_c] = b;
      cur_c++;
      if (cur_c >= COLS) cursor_newline();
    end
  endfunction

  function automatic void queue_result(logic [KIND_W-1:0] kind, logic [7:0] data,
                                       logic last);
    out_item_t r;
    r.kind           = kind;
    r.cursor_row_out = cur_r;
    r.cursor_col_out = cur_c;
    r.data_out       = data;
    r.last           = last;
    expected_results.push_back(r);
  endfunction

  // Updates the model for one accepted item and queues its results
  function automatic void predict_console(in_item_t it);
    int n;
    case (it.op)
      OP_PRINT: put_char(it.byte_in);
      OP_KEY: begin
        if (it.byte_in == CH_BACK) begin
          if (typed_len > 0) begin
            typed_len--;
            cursor_back();
          end
        end else if (it.byte_in == CH_NEWLINE) begin
          // enter: the line plus newline goes out as one run
          typed_line[typed_len] = CH_NEWLINE;
          n = typed_len + 1;
          put_char(CH_NEWLINE);
          for (int i = 0; i < n; i++) queue_result(KIND_LINE, typed_line[i], i + 1 == n);
          typed_len = '0;
          return;
        end else if (it.byte_in >= CH_PRINT_LO && it.byte_in <= CH_PRINT_HI &&
                     typed_len < LINE_CAP) begin
          typed_line[typed_len] = it.byte_in;
          typed_len++;
          put_char(it.byte_in);
        end
      end
      OP_READ: begin
        // out-of-range cells read as zero
        if (it.read_row < ROWS && it.read_col < COLS)
          queue_result(KIND_CELL, screen_model[it.read_row*COLS + it.read_col], 1'b1);
        else
          queue_result(KIND_CELL, 8'd0, 1'b1);
        return;
      end
      default: ;
    endcase
    queue_result(KIND_STATUS, 8'd0, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  function automatic in_item_t make_item(logic [OP_W-1:0] op, logic [7:0] b);
    in_item_t it;
    it.op       = op;
    it.byte_in  = b;
    it.read_row = 5'($urandom_range(31, 0));
    it.read_col = 6'($urandom_range(63, 0));
    return it;
  endfunction

  function automatic in_item_t cell_read(int row, int col);
    in_item_t it;
    it          = make_item(OP_READ, 8'($urandom_range(255, 0)));
    it.read_row = 5'(row);
    it.read_col = 6'(col);
    return it;
  endfunction

  function automatic in_item_t any_cell_read();
    return cell_read($urandom_range(ROWS-1, 0), $urandom_range(COLS-1, 0));
  endfunction

  // one transfer; bursts of random length separated by random gaps
  task automatic send_item(in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = (send_gap_max > 0) ? $urandom_range(send_gap_max, 0) : 0;
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    burst_left--;
    predict_console(it);
  endtask

  // sender pauses until every expected result has arrived
  task automatic wait_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: stall pattern with an optional long hold-off
  // ---------------------------------------------------------------------------
  initial begin : out_stall_gen
    int run_len;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request != 0) begin
        run_len      = hold_request;
        hold_request = 0;
        out_stall <= 1'b1;
      end else begin
        run_len = $urandom_range(4, 1);
        out_stall <= ($urandom_range(99, 0) < stall_pct);
      end
      repeat (run_len) @(posedge clk);
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // compare each output transfer with the oldest prediction
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d data %0d", out_data.kind, out_data.data_out);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("kind", 8'(want.kind), 8'(out_data.kind));
        check_field("cursor_row_out", 8'(want.cursor_row_out),
                    8'(out_data.cursor_row_out));
        check_field("cursor_col_out", 8'(want.cursor_col_out),
                    8'(out_data.cursor_col_out));
        check_field("data_out", want.data_out, out_data.data_out);
        check_field("last", 8'(want.last), 8'(out_data.last));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // corner cases of print, key, read and the undefined op
  task automatic test_directed();
    send_gap_max = 3;
    stall_pct    = 30;
    send_item(make_item(OP_PRINT, CH_BACK));       // backspace at top-left corner
    send_item(cell_read(0, 0));
    send_item(make_item(OP_PRINT, 8'd65));
    send_item(make_item(OP_PRINT, 8'd0));
    send_item(make_item(OP_PRINT, 8'd255));
    send_item(cell_read(0, 2));
    send_item(make_item(OP_PRINT, CH_BACK));
    send_item(make_item(OP_PRINT, CH_NEWLINE));
    send_item(make_item(OP_PRINT, CH_BACK));       // crosses back to the row above
    send_item(cell_read(ROWS-1, COLS-1));
    send_item(cell_read(ROWS, 0));                 // row out of range
    send_item(cell_read(0, COLS));                 // column out of range
    send_item(cell_read(31, 63));
    send_item(make_item(OP_UNDEF, CH_BACK));
    send_item(make_item(OP_KEY, CH_BACK));         // backspace on an empty line
    send_item(make_item(OP_KEY, 8'd104));
    send_item(make_item(OP_KEY, CH_PRINT_HI));
    send_item(make_item(OP_KEY, 8'd31));
    send_item(make_item(OP_KEY, 8'd128));
    send_item(make_item(OP_KEY, 8'd255));
    send_item(make_item(OP_KEY, 8'd0));
    send_item(make_item(OP_KEY, CH_BACK));
    send_item(make_item(OP_KEY, 8'd105));
    send_item(make_item(OP_KEY, CH_NEWLINE));
    send_item(cell_read(0, COLS-1));
    wait_drained();
  endtask

  function automatic logic [7:0] pick_key();
    int r;
    logic [7:0] b;
    r = $urandom_range(99, 0);
    if (r < 80) return 8'($urandom_range(CH_PRINT_HI, CH_PRINT_LO));
    if (r < 90) return CH_BACK;
    if (r < 95) return 8'($urandom_range(255, 128));
    do b = 8'($urandom_range(31, 0)); while (b == CH_BACK || b == CH_NEWLINE);
    return b;
  endfunction

  // typed lines ended by enter; the first one offers more items than the line cap
  task automatic test_typed_lines();
    int sent;
    int len;
    int line_no;
    sent    = 0;
    line_no = 0;
    send_gap_max = 4;
    stall_pct    = 35;
    while (sent < 130) begin
      if (line_no == 0) len = 68;
      else if ($urandom_range(5, 0) == 0) len = $urandom_range(72, 60);
      else len = $urandom_range(10, 0);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(9, 0) == 0) send_item(any_cell_read());
        else send_item(make_item(OP_KEY, pick_key()));
        sent++;
      end
      send_item(make_item(OP_KEY, CH_NEWLINE));
      sent++;
      line_no++;
    end
    wait_drained();
  endtask

  // printed text in segments: mixed text, wrapping runs, newline runs, reads
  task automatic test_print_stream();
    int sent;
    int seg;
    int n;
    int r;
    sent = 0;
    while (sent < 150) begin
      seg = $urandom_range(3, 0);
      // long wrapping runs go without idling on either side
      send_gap_max = (seg == 1) ? 0 : 4;
      stall_pct    = (seg == 1) ? 0 : 30;
      case (seg)
        0: n = $urandom_range(15, 3);
        1: n = $urandom_range(48, 40);
        2: n = $urandom_range(8, 3);
        default: n = $urandom_range(6, 3);
      endcase
      for (int k = 0; k < n; k++) begin
        r = $urandom_range(99, 0);
        case (seg)
          0: begin
            if (r < 10) send_item(make_item(OP_PRINT, CH_NEWLINE));
            else if (r < 18) send_item(make_item(OP_PRINT, CH_BACK));
            else if (r < 23) send_item(make_item(OP_PRINT, 8'($urandom_range(255, 0))));
            else if (r < 38) send_item(any_cell_read());
            else send_item(make_item(OP_PRINT, 8'($urandom_range(126, 32))));
          end
          1: send_item(make_item(OP_PRINT, 8'($urandom_range(126, 32))));
          2: send_item(make_item(OP_PRINT, CH_NEWLINE));
          default: send_item(any_cell_read());
        endcase
        sent++;
      end
    end
    wait_drained();
  endtask

  // receiver holds off while the sender keeps offering items
  task automatic test_output_hold();
    send_gap_max = 0;
    stall_pct    = 20;
    hold_request = 300;
    for (int k = 0; k < 20; k++) begin
      if (k % 5 == 4) send_item(make_item(OP_KEY, CH_NEWLINE));
      else send_item(make_item(OP_KEY, 8'($urandom_range(CH_PRINT_HI, CH_PRINT_LO))));
    end
    wait_drained();
  endtask

  // unshaped items over the full width of every field
  task automatic test_random_mix();
    in_item_t it;
    send_gap_max = 5;
    stall_pct    = 40;
    for (int k = 0; k < 85; k++) begin
      it.op       = 2'($urandom_range(3, 0));
      it.byte_in  = 8'($urandom_range(255, 0));
      it.read_row = 5'($urandom_range(31, 0));
      it.read_col = 6'($urandom_range(63, 0));
      send_item(it);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    model_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_typed_lines();
    test_print_stream();
    test_output_hold();
    test_random_mix();

    // let everything outstanding come out, then keep running before the final check
    in_valid <= 1'b0;
    for (int k = 0; k < DRAIN_LIMIT && expected_results.size() != 0; k++) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      mismatch_count++;
    end

    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
